/* rtl/sha1_pkg.sv */
// sha1_pkg: shared types, constants and round helpers of the sha-1 hash engine
// used by sha1_round_unit, sha1_datapath, sha1_ctrl and sha1_hash_engine
`timescale 1ns / 1ps

package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] five_words_t;  // element 0 is word a / digest word 0

  localparam int BLK_BITS = 512;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_SEG1 = 7'd20;
  localparam logic [6:0] ROUND_SEG2 = 7'd40;
  localparam logic [6:0] ROUND_SEG3 = 7'd60;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam five_words_t INIT_WORDS = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } sha1_state_e;

  typedef struct packed {
    logic       push;        // shift one byte into the block line
    logic [7:0] push_byte;
    logic       load_work;   // copy chaining words into working words
    logic       round_en;    // run one compression round
    logic [6:0] rnd;
    logic       update;      // fold working words into chaining words
    logic       init_chain;  // back to the initial values
  } sha1_ctrl_t;

  function automatic word_t round_k(input logic [6:0] t);
    word_t k;
    if (t < ROUND_SEG1) k = K0;
    else if (t < ROUND_SEG2) k = K1;
    else if (t < ROUND_SEG3) k = K2;
    else k = K3;
    return k;
  endfunction

  function automatic word_t round_f(input logic [6:0] t, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    if (t < ROUND_SEG1) f = (b & c) | (~b & d);
    else if (t < ROUND_SEG2) f = b ^ c ^ d;
    else if (t < ROUND_SEG3) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

/* rtl/sha1_round_unit.sv */
// sha1_round_unit: one sha-1 round and the next schedule word, shared by all 80 rounds
// depends on sha1_pkg
`timescale 1ns / 1ps

module sha1_round_unit (
  input  sha1_pkg::five_words_t work_i,
  input  logic [6:0]            rnd_i,
  input  sha1_pkg::word_t       w0_i,   // schedule word t
  input  sha1_pkg::word_t       w2_i,   // t + 2
  input  sha1_pkg::word_t       w8_i,   // t + 8
  input  sha1_pkg::word_t       w13_i,  // t + 13
  output sha1_pkg::five_words_t work_o,
  output sha1_pkg::word_t       w_new_o
);

  sha1_pkg::word_t a, b, c, d, e, f, k, mix;

  assign a = work_i[0];
  assign b = work_i[1];
  assign c = work_i[2];
  assign d = work_i[3];
  assign e = work_i[4];

  assign f = sha1_pkg::round_f(rnd_i, b, c, d);
  assign k = sha1_pkg::round_k(rnd_i);

  assign work_o[0] = {a[26:0], a[31:27]} + f + e + w0_i + k;
  assign work_o[1] = a;
  assign work_o[2] = {b[1:0], b[31:2]};
  assign work_o[3] = c;
  assign work_o[4] = d;

  // word t + 16 of the sliding schedule window
  assign mix = w13_i ^ w8_i ^ w2_i ^ w0_i;
  assign w_new_o = {mix[30:0], mix[31]};

endmodule

/* rtl/sha1_datapath.sv */
// sha1_datapath: block shift line, working words and chaining words
// depends on sha1_pkg and sha1_round_unit
`timescale 1ns / 1ps

module sha1_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1_pkg::sha1_ctrl_t  ctrl_i,
  output sha1_pkg::five_words_t chain_o
);

  logic [sha1_pkg::BLK_BITS-1:0] blk_q, blk_d;
  sha1_pkg::five_words_t work_q, work_d, work_step;
  sha1_pkg::five_words_t chain_q, chain_d;
  sha1_pkg::word_t w_new;

  // top word of the line is schedule word t
  sha1_round_unit u_round (
    .work_i  (work_q),
    .rnd_i   (ctrl_i.rnd),
    .w0_i    (blk_q[511:480]),
    .w2_i    (blk_q[447:416]),
    .w8_i    (blk_q[255:224]),
    .w13_i   (blk_q[95:64]),
    .work_o  (work_step),
    .w_new_o (w_new)
  );

  always_comb begin
    blk_d = blk_q;
    if (ctrl_i.push) begin
      blk_d = {blk_q[sha1_pkg::BLK_BITS-9:0], ctrl_i.push_byte};
    end else if (ctrl_i.round_en) begin
      blk_d = {blk_q[sha1_pkg::BLK_BITS-33:0], w_new};
    end
  end

  always_comb begin
    work_d = work_q;
    if (ctrl_i.load_work) begin
      work_d = chain_q;
    end else if (ctrl_i.round_en) begin
      work_d = work_step;
    end
  end

  always_comb begin
    chain_d = chain_q;
    if (ctrl_i.init_chain) begin
      chain_d = sha1_pkg::INIT_WORDS;
    end else if (ctrl_i.update) begin
      for (int i = 0; i < 5; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    work_q <= work_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha1_pkg::INIT_WORDS;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

endmodule

/* rtl/sha1_ctrl.sv */
// sha1_ctrl: sequencer for buffering, padding, round counting and digest hand-off
// depends on sha1_pkg
`timescale 1ns / 1ps

module sha1_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_req_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 out_free_i,
  output logic                 in_ready_o,
  output sha1_pkg::sha1_ctrl_t ctrl_o,
  output logic                 emit_o,
  output logic                 emit_ovf_o
);

  sha1_pkg::sha1_state_e state_q, state_d;
  logic [5:0]  fill_q;
  logic [60:0] byte_cnt_q;
  logic [60:0] cnt_inc;
  logic        ovf_q, fin_q, first_q, len_ok_q;
  logic [6:0]  rnd_q;
  logic        acc, acc_fin, push, blk_full;
  logic [63:0] bit_count;
  logic [2:0]  len_idx;
  logic [7:0]  len_byte, pad_byte;

  assign cnt_inc   = byte_cnt_q + 61'd1;
  assign bit_count = {byte_cnt_q, 3'b000};
  assign len_idx   = fill_q[2:0];
  assign len_byte  = bit_count[{~len_idx, 3'b111} -: 8];

  // outputs
  always_comb begin
    in_ready_o = (state_q == sha1_pkg::ST_IDLE);
    acc        = in_valid_i && in_ready_o;
    acc_fin    = acc && (in_req_i == sha1_pkg::REQ_FINISH);
    if (first_q) begin
      pad_byte = sha1_pkg::PAD_BYTE;
    end else if (len_ok_q && (fill_q >= sha1_pkg::LEN_POS)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
    case (state_q)
      sha1_pkg::ST_IDLE: push = acc && (in_req_i == sha1_pkg::REQ_APPEND) && !ovf_q;
      sha1_pkg::ST_PAD:  push = 1'b1;
      default:           push = 1'b0;
    endcase
    blk_full = push && (fill_q == sha1_pkg::FILL_LAST);

    ctrl_o.push       = push;
    ctrl_o.push_byte  = (state_q == sha1_pkg::ST_PAD) ? pad_byte : in_byte_i;
    ctrl_o.load_work  = blk_full;
    ctrl_o.round_en   = (state_q == sha1_pkg::ST_ROUND);
    ctrl_o.rnd        = rnd_q;
    ctrl_o.update     = (state_q == sha1_pkg::ST_UPDATE);
    emit_o            = (state_q == sha1_pkg::ST_EMIT) && out_free_i;
    ctrl_o.init_chain = emit_o;
    emit_ovf_o        = ovf_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (acc_fin) begin
          state_d = ovf_q ? sha1_pkg::ST_EMIT : sha1_pkg::ST_PAD;
        end else if (blk_full) begin
          state_d = sha1_pkg::ST_ROUND;
        end
      end
      sha1_pkg::ST_PAD: begin
        if (blk_full) state_d = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_ROUND: begin
        if (rnd_q == sha1_pkg::ROUND_LAST) state_d = sha1_pkg::ST_UPDATE;
      end
      sha1_pkg::ST_UPDATE: begin
        if (!fin_q) state_d = sha1_pkg::ST_IDLE;
        else if (len_ok_q) state_d = sha1_pkg::ST_EMIT;
        else state_d = sha1_pkg::ST_PAD;
      end
      sha1_pkg::ST_EMIT: begin
        if (out_free_i) state_d = sha1_pkg::ST_IDLE;
      end
      default: state_d = sha1_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha1_pkg::ST_IDLE;
      fill_q     <= '0;
      byte_cnt_q <= '0;
      ovf_q      <= 1'b0;
      fin_q      <= 1'b0;
      first_q    <= 1'b0;
      len_ok_q   <= 1'b0;
      rnd_q      <= '0;
    end else begin
      state_q <= state_d;
      if (emit_o) begin
        fill_q     <= '0;
        byte_cnt_q <= '0;
        ovf_q      <= 1'b0;
        fin_q      <= 1'b0;
      end else begin
        if (push) fill_q <= fill_q + 6'd1;
        if (push && (state_q == sha1_pkg::ST_IDLE)) begin
          byte_cnt_q <= cnt_inc;
          if (cnt_inc == '0) ovf_q <= 1'b1;
        end
        if (acc_fin) fin_q <= 1'b1;
      end
      // padding phase flags
      if (acc_fin) begin
        first_q  <= 1'b1;
        len_ok_q <= 1'b0;
      end else if (state_q == sha1_pkg::ST_PAD) begin
        first_q <= 1'b0;
        if (first_q && (fill_q < sha1_pkg::LEN_POS)) len_ok_q <= 1'b1;
      end else if ((state_q == sha1_pkg::ST_UPDATE) && fin_q) begin
        len_ok_q <= 1'b1;
      end
      if (blk_full) begin
        rnd_q <= '0;
      end else if (state_q == sha1_pkg::ST_ROUND) begin
        rnd_q <= rnd_q + 7'd1;
      end
    end
  end

endmodule

/* rtl/sha1_hash_engine.sv */
// sha1_hash_engine: top level of the sha-1 hash engine with the result register
// depends on sha1_pkg, sha1_ctrl and sha1_datapath
`timescale 1ns / 1ps

// channel   | dir | tdata                          | tuser
// ----------+-----+--------------------------------+--------------------------------
// s_axis    | in  | [7:0] data_byte                | [0] req_type (0 append, 1 finish)
// m_axis    | out | [159:0] digest_w0..digest_w4   | [0] status (1 message too long)
//
// append: takes one byte; the 64th byte of a block runs the 80 rounds on the shared unit
// plus a chaining update
// finish: pad and length bytes one per cycle to the block end, one or two compressions
// (none after an overflow), then the digest goes to the result register once it is free
// reset loads the initial chaining words and clears counters and flags
// s_axis_tready is low during that work; a waiting result stalls only the next hand-off

module sha1_hash_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic           s_axis_tuser,   // [0] req_type
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [159:0]   m_axis_tdata,   // [31:0] w0, [63:32] w1, [95:64] w2, [127:96] w3,
                                         // [159:128] w4
  output logic           m_axis_tuser    // [0] status
);

  sha1_pkg::sha1_ctrl_t  ctrl;
  sha1_pkg::five_words_t chain;
  logic                  emit, emit_ovf, out_free;
  logic                  out_valid_q, status_q;
  logic [159:0]          digest_q;

  // result register frees when empty or being taken this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  sha1_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_req_i   (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl),
    .emit_o     (emit),
    .emit_ovf_o (emit_ovf)
  );

  sha1_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .chain_o (chain)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // overflowed messages report status 1 with an all-zero digest
  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= emit_ovf;
      digest_q <= emit_ovf ? 160'd0 : chain;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = digest_q;
  assign m_axis_tuser  = status_q;

endmodule

/* rtl/sha1_checker.sv */
// sha1_checker: port-level assertions for sha1_hash_engine, attached by bind
// depends on the port list of sha1_hash_engine
`timescale 1ns / 1ps

module sha1_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // error results carry no digest
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 160'd0)
    else $error("error result with nonzero digest");

  // an appended byte never produces a result
  a_append_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after append item");

  // a finish item always takes s_axis_tready low, as the engine leaves the idle state
  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser |=> !s_axis_tready)
    else $error("ready right after finish item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
